/* sv/rfrf_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// rfrf_pkg
// Types and constants shared by the radio frame receive filter modules.
// ============================================================================
package rfrf_pkg;

    // frame layout
    localparam int HDR_BYTES       = 15;
    localparam int MIN_FRAME_BYTES = 16;
    localparam int XOR_START_POS   = 3;
    localparam int OFS_HEAD        = 0;
    localparam int OFS_TARGET      = 1;
    localparam int OFS_GROUP       = 5;
    localparam int OFS_SEQ         = 9;
    localparam int OFS_PACK        = 10;
    localparam int OFS_TYPE        = 11;
    localparam int OFS_LEN         = 14;

    // preamble wait: limit 110 less a margin of 5
    localparam int PRE_WAIT_LIMIT  = 105;

    // ack table slots: 15 devices per 16-bit word
    localparam int SLOT_SPAN       = 15;
    localparam int SLOT_RECIP      = 137;
    localparam int SLOT_RECIP_SH   = 11;

    localparam logic [7:0] SEQ_RESET = 8'hFF;

    typedef enum logic [2:0] {
        CFG_OWN_UID       = 3'd0,
        CFG_PAIRED_UID    = 3'd1,
        CFG_BROADCAST_UID = 3'd2,
        CFG_DEVICE_NUMBER = 3'd3,
        CFG_HEAD_MARKER   = 3'd4,
        CFG_END_MARKER    = 3'd5,
        CFG_TYPE_CODES    = 3'd6,
        CFG_WINDOW_EXTEND = 3'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        ACT_CHECK_ERROR   = 4'd0,
        ACT_NOT_ADDRESSED = 4'd1,
        ACT_NEW_DATA      = 4'd2,
        ACT_REPEAT_NEW    = 4'd3,
        ACT_REPEAT_OLD    = 4'd4,
        ACT_ACK           = 4'd5,
        ACT_PRE_IGNORED   = 4'd6,
        ACT_WAIT_START    = 4'd7,
        ACT_WINDOW_EXTEND = 4'd8
    } action_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
        logic [6:0] signal_strength;
    } in_beat_t;

    typedef struct packed {
        action_t     action;
        logic        send_ack;
        logic        ack_immediate;
        logic [31:0] group_uid;
        logic [7:0]  echo_sequence;
        logic [7:0]  echo_pack;
        logic [7:0]  window_ticks;
        logic [6:0]  rssi_out;
        logic [7:0]  body_length;
    } out_beat_t;

    // location of this device's bit in the ack table
    typedef struct packed {
        logic [4:0] byte_index;
        logic [2:0] bit_index;
        logic       in_table;
    } slot_sel_t;

    // frame summary seen at the final byte
    typedef struct packed {
        logic        pos_ok;
        logic        xor_ok;
        logic [7:0]  head_byte;
        logic [31:0] target_uid;
        logic [31:0] group_uid;
        logic [7:0]  seq;
        logic [7:0]  pack;
        logic [7:0]  type_byte;
        logic [7:0]  body_len;
        logic        table_bit;
    } frame_view_t;

endpackage

/* sv/rfrf_frame_track.sv */
`timescale 1ns / 1ps
// ============================================================================
// rfrf_frame_track
// Per-frame byte tracking: position, running XOR, header capture and the
// ack table bit of this device.
// ============================================================================
module rfrf_frame_track import rfrf_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 250
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        beat_en,
    input  in_beat_t    beat,
    input  slot_sel_t   slot,
    output frame_view_t view
);

    logic [7:0] pos_reg, pos_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] recent0_reg, recent0_next;
    logic [7:0] recent1_reg, recent1_next;
    logic       tbit_reg, tbit_next;
    logic [7:0] hdr_reg [HDR_BYTES];

    logic [7:0] xor_now;
    logic [9:0] table_pos;
    logic       table_hit;
    logic       tbit_now;

    always_comb begin
        xor_now   = (pos_reg >= 8'(XOR_START_POS)) ? (xor_reg ^ recent1_reg) : xor_reg;
        table_pos = 10'(HDR_BYTES) + {2'b00, hdr_reg[OFS_LEN]} + {5'b00000, slot.byte_index};
        table_hit = slot.in_table && (pos_reg >= 8'(HDR_BYTES))
                    && ({2'b00, pos_reg} == table_pos);
        tbit_now  = table_hit ? beat.frame_byte[slot.bit_index] : tbit_reg;
    end

    always_comb begin
        if (beat.frame_last) begin
            pos_next     = '0;
            xor_next     = '0;
            recent0_next = '0;
            recent1_next = '0;
            tbit_next    = 1'b0;
        end else begin
            pos_next     = (pos_reg == 8'hFF) ? pos_reg : pos_reg + 8'd1;
            xor_next     = xor_now;
            recent0_next = beat.frame_byte;
            recent1_next = recent0_reg;
            tbit_next    = tbit_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            xor_reg     <= '0;
            recent0_reg <= '0;
            recent1_reg <= '0;
            tbit_reg    <= 1'b0;
        end else if (beat_en) begin
            pos_reg     <= pos_next;
            xor_reg     <= xor_next;
            recent0_reg <= recent0_next;
            recent1_reg <= recent1_next;
            tbit_reg    <= tbit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_en && (pos_reg < 8'(HDR_BYTES))) begin
            hdr_reg[pos_reg[3:0]] <= beat.frame_byte;
        end
    end

    always_comb begin
        view.pos_ok     = (pos_reg >= 8'(MIN_FRAME_BYTES - 1))
                          && (pos_reg < 8'(MAX_FRAME_BYTES));
        view.xor_ok     = (recent0_reg == xor_now);
        view.head_byte  = hdr_reg[OFS_HEAD];
        view.target_uid = {hdr_reg[OFS_TARGET + 3], hdr_reg[OFS_TARGET + 2],
                           hdr_reg[OFS_TARGET + 1], hdr_reg[OFS_TARGET]};
        view.group_uid  = {hdr_reg[OFS_GROUP + 3], hdr_reg[OFS_GROUP + 2],
                           hdr_reg[OFS_GROUP + 1], hdr_reg[OFS_GROUP]};
        view.seq        = hdr_reg[OFS_SEQ];
        view.pack       = hdr_reg[OFS_PACK];
        view.type_byte  = hdr_reg[OFS_TYPE];
        view.body_len   = hdr_reg[OFS_LEN];
        view.table_bit  = tbit_now;
    end

endmodule

/* sv/radio_frame_receive_filter.sv */
`timescale 1ns / 1ps
// ============================================================================
// radio_frame_receive_filter
// Checks received radio frames byte by byte and classifies each frame.
// ============================================================================
// The block takes one payload byte per clock cycle. Every byte updates the
// frame tracking registers as it is accepted; the final byte of a frame is
// checked and classified in the same cycle and its result appears on the
// m_ channel on the following cycle, one result per frame. The input only
// stalls on a final byte while the previous frame's result is still held by
// the output register and not taken that cycle. Configuration is written
// through cfg_wr_en, cfg_index and cfg_wr_data while no frame is in flight.
module radio_frame_receive_filter import rfrf_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 250,
    parameter int ACK_TABLE_BYTES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_beat,

    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_beat
);

    logic [31:0] own_uid_reg;
    logic [31:0] paired_uid_reg;
    logic [31:0] bcast_uid_reg;
    logic [7:0]  head_marker_reg;
    logic [7:0]  end_marker_reg;
    logic [23:0] type_codes_reg;
    logic [7:0]  win_extend_reg;
    slot_sel_t   slot_reg, slot_next;

    logic [7:0]  last_seq_reg, last_seq_next;
    logic [7:0]  last_pack_reg, last_pack_next;
    logic        wait_flag_reg, wait_flag_next;

    logic        m_valid_reg, m_valid_next;
    out_beat_t   m_beat_reg, m_beat_next;

    logic        beat_en;
    logic        frame_done;
    frame_view_t view;

    logic [14:0] slot_prod;
    logic [3:0]  slot_quo;
    logic [6:0]  slot_rem;

    logic        check_ok;
    logic        to_own;
    logic        addr_ok;

    // ack table slot of the device number, found on the config write
    always_comb begin
        slot_prod            = 15'(cfg_wr_data[6:0]) * 15'(SLOT_RECIP);
        slot_quo             = slot_prod[14:SLOT_RECIP_SH];
        slot_rem             = cfg_wr_data[6:0] - 7'({3'b000, slot_quo} * 7'(SLOT_SPAN));
        slot_next.byte_index = {slot_quo, 1'b0} + {4'b0000, slot_rem[3]};
        slot_next.bit_index  = slot_rem[2:0];
        slot_next.in_table   = {1'b0, slot_next.byte_index} < 6'(ACK_TABLE_BYTES);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_uid_reg     <= '0;
            paired_uid_reg  <= '0;
            bcast_uid_reg   <= '0;
            head_marker_reg <= '0;
            end_marker_reg  <= '0;
            type_codes_reg  <= '0;
            win_extend_reg  <= '0;
            slot_reg        <= '{byte_index: 5'd0, bit_index: 3'd0, in_table: 1'b1};
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_OWN_UID:       own_uid_reg     <= cfg_wr_data;
                CFG_PAIRED_UID:    paired_uid_reg  <= cfg_wr_data;
                CFG_BROADCAST_UID: bcast_uid_reg   <= cfg_wr_data;
                CFG_DEVICE_NUMBER: slot_reg        <= slot_next;
                CFG_HEAD_MARKER:   head_marker_reg <= cfg_wr_data[7:0];
                CFG_END_MARKER:    end_marker_reg  <= cfg_wr_data[7:0];
                CFG_TYPE_CODES:    type_codes_reg  <= cfg_wr_data[23:0];
                CFG_WINDOW_EXTEND: win_extend_reg  <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    // only a final beat needs room in the output register
    assign s_ready    = !m_valid_reg || m_ready || !s_beat.frame_last;
    assign beat_en    = s_valid && s_ready;
    assign frame_done = beat_en && s_beat.frame_last;

    rfrf_frame_track #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .beat_en (beat_en),
        .beat    (s_beat),
        .slot    (slot_reg),
        .view    (view)
    );

    always_comb begin
        check_ok = view.pos_ok && view.xor_ok
                   && (view.head_byte == head_marker_reg)
                   && (s_beat.frame_byte == end_marker_reg);
        to_own   = (view.target_uid == own_uid_reg);
        addr_ok  = (view.group_uid == paired_uid_reg)
                   && ((view.target_uid == bcast_uid_reg) || to_own);
    end

    always_comb begin
        m_beat_next    = '0;
        m_beat_next.action = ACT_CHECK_ERROR;
        last_seq_next  = last_seq_reg;
        last_pack_next = last_pack_reg;
        wait_flag_next = wait_flag_reg;
        priority if (!check_ok) begin
            m_beat_next.action = ACT_CHECK_ERROR;
        end else if (!addr_ok) begin
            m_beat_next.action = ACT_NOT_ADDRESSED;
        end else if (view.type_byte == type_codes_reg[7:0]) begin
            wait_flag_next            = 1'b0;
            m_beat_next.group_uid     = view.group_uid;
            m_beat_next.echo_sequence = view.seq;
            m_beat_next.echo_pack     = view.pack;
            priority if (view.pack != last_pack_reg) begin
                last_seq_next           = view.seq;
                last_pack_next          = view.pack;
                m_beat_next.action      = ACT_NEW_DATA;
                m_beat_next.body_length = view.body_len;
                m_beat_next.send_ack    = !view.table_bit;
            end else if (view.seq != last_seq_reg) begin
                last_seq_next        = view.seq;
                m_beat_next.action   = ACT_REPEAT_NEW;
                m_beat_next.send_ack = !view.table_bit;
            end else begin
                m_beat_next.action = ACT_REPEAT_OLD;
            end
            m_beat_next.ack_immediate = m_beat_next.send_ack && to_own;
        end else if (view.type_byte == type_codes_reg[15:8]) begin
            m_beat_next.action   = ACT_ACK;
            m_beat_next.rssi_out = s_beat.signal_strength;
        end else if (view.type_byte == type_codes_reg[23:16]) begin
            if (view.table_bit && !wait_flag_reg) begin
                wait_flag_next = 1'b1;
                if (view.seq < 8'(PRE_WAIT_LIMIT)) begin
                    m_beat_next.action       = ACT_WAIT_START;
                    m_beat_next.window_ticks = 8'(PRE_WAIT_LIMIT) - view.seq;
                end else begin
                    m_beat_next.action       = ACT_WINDOW_EXTEND;
                    m_beat_next.window_ticks = win_extend_reg;
                end
            end else begin
                m_beat_next.action = ACT_PRE_IGNORED;
            end
        end else begin
            m_beat_next.action = ACT_NOT_ADDRESSED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_seq_reg  <= SEQ_RESET;
            last_pack_reg <= SEQ_RESET;
            wait_flag_reg <= 1'b0;
        end else if (frame_done) begin
            last_seq_reg  <= last_seq_next;
            last_pack_reg <= last_pack_next;
            wait_flag_reg <= wait_flag_next;
        end
    end

    // result register
    always_comb begin
        if (frame_done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_done) begin
            m_beat_reg <= m_beat_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

    // input stalls only behind an untaken result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a pending result");

    // a new result follows a final beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_beat.frame_last))
        else $error("result without a final beat");

    // ack request only for fresh data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_beat.send_ack) |->
            (m_beat.action == ACT_NEW_DATA || m_beat.action == ACT_REPEAT_NEW))
        else $error("ack requested for wrong action");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_beat.ack_immediate) |-> m_beat.send_ack)
        else $error("immediate ack without ack request");

endmodule

/* bench/radio_frame_receive_filter_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// radio_frame_receive_filter_test
// Self-checking bench for the radio frame receive filter. Frames are built
// byte by byte with a correct or broken head, end marker and XOR check, and
// with addressing, type, sequence, pack and ack table contents chosen to
// reach every action. An in-bench model of the filter predicts one verdict
// per frame as its bytes are accepted, and every result beat is compared
// field by field with the oldest prediction. Both sides idle at random, a
// long receiver hold-off makes the block stall its input, and the
// configuration is rewritten between phases while the block is idle.
// ============================================================================
module radio_frame_receive_filter_test;
    import rfrf_pkg::*;

    localparam int TABLE_BYTES = 16;
    localparam int FRAME_LIMIT = 250;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [1:0] {
        FLAW_NONE,
        FLAW_HEAD,
        FLAW_END,
        FLAW_XOR
    } flaw_t;

    typedef enum logic [1:0] {
        SLOT_RANDOM,
        SLOT_CLEAR,
        SLOT_SET
    } slot_mode_t;

    typedef struct {
        int          total;
        logic [31:0] target;
        logic [31:0] group;
        logic [7:0]  seq;
        logic [7:0]  pack;
        logic [7:0]  kind;
        logic [7:0]  len_field;
        slot_mode_t  slot;
        flaw_t       flaw;
    } frame_spec_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    in_beat_t    s_beat;
    logic        m_valid;
    logic        m_ready;
    out_beat_t   m_beat;

    // filter settings as last written
    logic [31:0] my_uid       = '0;
    logic [31:0] pair_uid     = '0;
    logic [31:0] bcast_uid    = '0;
    logic [6:0]  dev_slot     = '0;
    logic [7:0]  head_code    = '0;
    logic [7:0]  end_code     = '0;
    logic [23:0] type_map     = '0;
    logic [7:0]  extend_ticks = '0;

    // receive tracking
    int          rx_pos    = 0;
    logic [7:0]  rx_xor    = '0;
    logic [7:0]  hdr [HDR_BYTES] = '{default: '0};
    logic [7:0]  recent [2]      = '{default: '0};
    logic [7:0]  tbl [TABLE_BYTES] = '{default: '0};
    logic [7:0]  last_seq  = SEQ_RESET;
    logic [7:0]  last_pack = SEQ_RESET;
    logic        wait_flag = 1'b0;

    out_beat_t   frame_verdicts [$];

    int          error_count = 0;
    int          bytes_sent  = 0;
    bit          steady      = 1'b0;
    int          hold_req    = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;

    radio_frame_receive_filter #(
        .MAX_FRAME_BYTES(FRAME_LIMIT),
        .ACK_TABLE_BYTES(TABLE_BYTES)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_beat     (s_beat),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_beat     (m_beat)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("radio_frame_receive_filter_test NOT OK");
        $finish;
    end

    function automatic void absorb_byte(in_beat_t beat);
        out_beat_t   verdict;
        logic [31:0] target;
        logic [31:0] group;
        logic [7:0]  kind;
        logic [7:0]  seq;
        logic [7:0]  pack;
        logic        to_own;
        logic        slot;
        int          start;
        int          n;
        int          b;
        int          idx;
        if (rx_pos >= XOR_START_POS) begin
            rx_xor ^= recent[1];
        end
        if (rx_pos < HDR_BYTES) begin
            hdr[rx_pos] = beat.frame_byte;
        end else begin
            start = HDR_BYTES + int'(hdr[OFS_LEN]);
            if (rx_pos >= start && rx_pos - start < TABLE_BYTES) begin
                tbl[rx_pos - start] = beat.frame_byte;
            end
        end
        if (!beat.frame_last) begin
            recent[1] = recent[0];
            recent[0] = beat.frame_byte;
            if (rx_pos < 255) begin
                rx_pos++;
            end
            return;
        end

        // this device's bit in the ack table
        n = int'(dev_slot);
        b = n % SLOT_SPAN;
        idx = (n / SLOT_SPAN) * 2 + (b >> 3);
        slot = (idx < TABLE_BYTES) ? tbl[idx][b % 8] : 1'b0;

        verdict = '0;
        target = {hdr[OFS_TARGET + 3], hdr[OFS_TARGET + 2], hdr[OFS_TARGET + 1],
                  hdr[OFS_TARGET]};
        group = {hdr[OFS_GROUP + 3], hdr[OFS_GROUP + 2], hdr[OFS_GROUP + 1], hdr[OFS_GROUP]};
        kind = hdr[OFS_TYPE];
        seq = hdr[OFS_SEQ];
        pack = hdr[OFS_PACK];
        to_own = (target == my_uid);
        if (rx_pos + 1 < MIN_FRAME_BYTES || rx_pos >= FRAME_LIMIT || hdr[OFS_HEAD] != head_code
                || beat.frame_byte != end_code || recent[0] != rx_xor) begin
            verdict.action = ACT_CHECK_ERROR;
        end else if (group != pair_uid || !(target == bcast_uid || to_own)) begin
            verdict.action = ACT_NOT_ADDRESSED;
        end else if (kind == type_map[7:0]) begin
            wait_flag = 1'b0;
            verdict.group_uid = group;
            verdict.echo_sequence = seq;
            verdict.echo_pack = pack;
            if (pack != last_pack) begin
                last_seq = seq;
                last_pack = pack;
                verdict.action = ACT_NEW_DATA;
                verdict.body_length = hdr[OFS_LEN];
                verdict.send_ack = !slot;
            end else if (seq != last_seq) begin
                last_seq = seq;
                verdict.action = ACT_REPEAT_NEW;
                verdict.send_ack = !slot;
            end else begin
                verdict.action = ACT_REPEAT_OLD;
            end
            verdict.ack_immediate = verdict.send_ack && to_own;
        end else if (kind == type_map[15:8]) begin
            verdict.action = ACT_ACK;
            verdict.rssi_out = beat.signal_strength;
        end else if (kind == type_map[23:16]) begin
            if (slot && !wait_flag) begin
                wait_flag = 1'b1;
                if (int'(seq) < PRE_WAIT_LIMIT) begin
                    verdict.action = ACT_WAIT_START;
                    verdict.window_ticks = 8'(PRE_WAIT_LIMIT - int'(seq));
                end else begin
                    verdict.action = ACT_WINDOW_EXTEND;
                    verdict.window_ticks = extend_ticks;
                end
            end else begin
                verdict.action = ACT_PRE_IGNORED;
            end
        end else begin
            verdict.action = ACT_NOT_ADDRESSED;
        end
        frame_verdicts.push_back(verdict);

        rx_pos = 0;
        rx_xor = '0;
        recent[0] = '0;
        recent[1] = '0;
        foreach (tbl[i]) begin
            tbl[i] = '0;
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("%0t: %s: got %0h expected %0h", $time, what, got, want);
    endtask

    // result checker
    always @(posedge aclk) begin : check_results
        out_beat_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (frame_verdicts.size() == 0) begin
                report_mismatch("result with no frame pending", m_beat.action, '0);
            end else begin
                want = frame_verdicts.pop_front();
                if (m_beat.action !== want.action)
                    report_mismatch("action", m_beat.action, want.action);
                if (m_beat.send_ack !== want.send_ack)
                    report_mismatch("send_ack", m_beat.send_ack, want.send_ack);
                if (m_beat.ack_immediate !== want.ack_immediate)
                    report_mismatch("ack_immediate", m_beat.ack_immediate, want.ack_immediate);
                if (m_beat.group_uid !== want.group_uid)
                    report_mismatch("group_uid", m_beat.group_uid, want.group_uid);
                if (m_beat.echo_sequence !== want.echo_sequence)
                    report_mismatch("echo_sequence", m_beat.echo_sequence, want.echo_sequence);
                if (m_beat.echo_pack !== want.echo_pack)
                    report_mismatch("echo_pack", m_beat.echo_pack, want.echo_pack);
                if (m_beat.window_ticks !== want.window_ticks)
                    report_mismatch("window_ticks", m_beat.window_ticks, want.window_ticks);
                if (m_beat.rssi_out !== want.rssi_out)
                    report_mismatch("rssi_out", m_beat.rssi_out, want.rssi_out);
                if (m_beat.body_length !== want.body_length)
                    report_mismatch("body_length", m_beat.body_length, want.body_length);
            end
        end
    end

    // result receiver with random stalls and long hold-offs
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 18);
            end
        end
    end

    task automatic send_beat(in_beat_t beat);
        if (!steady && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_beat <= beat;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        absorb_byte(beat);
        bytes_sent++;
    endtask

    task automatic send_frame(frame_spec_t sp);
        logic [7:0] img [256];
        logic [7:0] chk;
        logic [7:0] nz;
        int         n;
        int         spot;
        in_beat_t   beat;
        foreach (img[i]) begin
            img[i] = 8'($urandom_range(0, 255));
        end
        img[OFS_HEAD] = head_code;
        for (int k = 0; k < 4; k++) begin
            img[OFS_TARGET + k] = sp.target[8 * k +: 8];
            img[OFS_GROUP + k] = sp.group[8 * k +: 8];
        end
        img[OFS_SEQ] = sp.seq;
        img[OFS_PACK] = sp.pack;
        img[OFS_TYPE] = sp.kind;
        img[OFS_LEN] = sp.len_field;
        n = int'(dev_slot);
        spot = HDR_BYTES + int'(sp.len_field) + (n / SLOT_SPAN) * 2 + ((n % SLOT_SPAN) >> 3);
        if (spot < sp.total - 2 && sp.slot != SLOT_RANDOM) begin
            img[spot][(n % SLOT_SPAN) % 8] = (sp.slot == SLOT_SET);
        end
        nz = 8'($urandom_range(1, 255));
        if (sp.total >= 3) begin
            chk = '0;
            for (int i = 1; i <= sp.total - 3; i++) begin
                chk ^= img[i];
            end
            img[sp.total - 2] = (sp.flaw == FLAW_XOR) ? chk ^ nz : chk;
            img[sp.total - 1] = (sp.flaw == FLAW_END) ? end_code ^ nz : end_code;
        end
        if (sp.flaw == FLAW_HEAD) begin
            img[OFS_HEAD] ^= nz;
        end
        for (int i = 0; i < sp.total; i++) begin
            beat.frame_byte = img[i];
            beat.frame_last = (i == sp.total - 1);
            beat.signal_strength = 7'($urandom_range(0, 127));
            send_beat(beat);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (frame_verdicts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    task automatic load_settings();
        drain();
        write_reg(CFG_OWN_UID, my_uid);
        write_reg(CFG_PAIRED_UID, pair_uid);
        write_reg(CFG_BROADCAST_UID, bcast_uid);
        write_reg(CFG_DEVICE_NUMBER, {25'd0, dev_slot});
        write_reg(CFG_HEAD_MARKER, {24'd0, head_code});
        write_reg(CFG_END_MARKER, {24'd0, end_code});
        write_reg(CFG_TYPE_CODES, {8'd0, type_map});
        write_reg(CFG_WINDOW_EXTEND, {24'd0, extend_ticks});
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void pick_settings();
        logic [7:0] d;
        logic [7:0] a;
        logic [7:0] p;
        my_uid = $urandom;
        pair_uid = $urandom;
        bcast_uid = $urandom;
        dev_slot = 7'($urandom_range(0, 119));
        head_code = 8'($urandom_range(0, 255));
        end_code = 8'($urandom_range(0, 255));
        extend_ticks = 8'($urandom_range(0, 255));
        d = 8'($urandom_range(0, 255));
        do a = 8'($urandom_range(0, 255)); while (a == d);
        do p = 8'($urandom_range(0, 255)); while (p == d || p == a);
        type_map = {p, a, d};
    endfunction

    function automatic logic [7:0] spare_code();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == type_map[7:0] || c == type_map[15:8] || c == type_map[23:16]);
        return c;
    endfunction

    function automatic logic [31:0] stray_uid();
        logic [31:0] u;
        do u = $urandom; while (u == my_uid || u == bcast_uid);
        return u;
    endfunction

    function automatic frame_spec_t good_spec(logic [7:0] kind);
        frame_spec_t sp;
        sp.len_field = 8'($urandom_range(0, 8));
        sp.total = 17 + int'(sp.len_field) + int'($urandom_range(0, 18));
        sp.target = my_uid;
        sp.group = pair_uid;
        sp.seq = 8'($urandom_range(0, 255));
        sp.pack = 8'($urandom_range(0, 255));
        sp.kind = kind;
        sp.slot = SLOT_RANDOM;
        sp.flaw = FLAW_NONE;
        return sp;
    endfunction

    function automatic frame_spec_t random_spec();
        frame_spec_t sp;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            sp = good_spec(type_map[7:0]);
            if ($urandom_range(0, 99) < 50) begin
                sp.pack = last_pack;
                if ($urandom_range(0, 1) == 1) begin
                    sp.seq = last_seq;
                end
            end
        end else if (pick < 55) begin
            sp = good_spec(type_map[15:8]);
        end else if (pick < 80) begin
            sp = good_spec(type_map[23:16]);
            if ($urandom_range(0, 99) < 70) begin
                sp.slot = SLOT_SET;
            end
        end else begin
            sp = good_spec(spare_code());
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            sp.target = bcast_uid;
        end else if (pick < 50) begin
            sp.target = stray_uid();
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            sp.flaw = FLAW_HEAD;
        end else if (pick < 10) begin
            sp.flaw = FLAW_END;
        end else if (pick < 15) begin
            sp.flaw = FLAW_XOR;
        end else if (pick < 20) begin
            sp.group = sp.group ^ (32'd1 << $urandom_range(0, 31));
        end else if (pick < 26) begin
            sp.total = $urandom_range(1, 15);
        end else if (pick < 30) begin
            sp.len_field = 8'($urandom_range(0, 255));
        end else if (pick < 32) begin
            sp.total = $urandom_range(240, 251);
        end
        return sp;
    endfunction

    // settings at reset: every code zero, so data wins
    task automatic test_reset_state();
        frame_spec_t sp;
        sp = good_spec(8'h00);
        sp.seq = SEQ_RESET;
        sp.pack = SEQ_RESET;
        send_frame(sp);
        sp.seq = 8'h07;
        send_frame(sp);
        sp.pack = 8'h01;
        send_frame(sp);
    endtask

    task automatic test_actions();
        frame_spec_t sp;
        logic [7:0]  data_t;
        logic [7:0]  ack_t;
        logic [7:0]  pre_t;
        logic [7:0]  pre_seqs [4];
        pick_settings();
        load_settings();
        data_t = type_map[7:0];
        ack_t = type_map[15:8];
        pre_t = type_map[23:16];

        sp = good_spec(data_t);
        sp.pack = last_pack + 8'd1;
        sp.slot = SLOT_CLEAR;
        sp.total = HDR_BYTES + int'(sp.len_field) + TABLE_BYTES + 2;
        send_frame(sp);
        sp.seq = sp.seq + 8'd1;
        sp.target = bcast_uid;
        send_frame(sp);
        send_frame(sp);
        sp.pack = last_pack + 8'd1;
        sp.target = my_uid;
        sp.slot = SLOT_SET;
        send_frame(sp);
        send_frame(good_spec(ack_t));

        pre_seqs = '{8'd0, 8'(PRE_WAIT_LIMIT - 1), 8'(PRE_WAIT_LIMIT), 8'hFF};
        foreach (pre_seqs[i]) begin
            send_frame(good_spec(data_t));
            sp = good_spec(pre_t);
            sp.slot = SLOT_SET;
            sp.total = HDR_BYTES + int'(sp.len_field) + TABLE_BYTES + 2;
            sp.seq = pre_seqs[i];
            send_frame(sp);
            send_frame(sp);
        end
        send_frame(good_spec(data_t));
        sp.slot = SLOT_CLEAR;
        send_frame(sp);

        send_frame(good_spec(spare_code()));
        sp = good_spec(data_t);
        sp.group = ~pair_uid;
        send_frame(sp);
        sp = good_spec(data_t);
        sp.target = stray_uid();
        send_frame(sp);
        sp = good_spec(data_t);
        sp.flaw = FLAW_HEAD;
        send_frame(sp);
        sp.flaw = FLAW_END;
        send_frame(sp);
        sp.flaw = FLAW_XOR;
        send_frame(sp);
        sp.flaw = FLAW_NONE;
        sp.total = MIN_FRAME_BYTES - 1;
        send_frame(sp);
        sp.total = 1;
        send_frame(sp);
        sp.pack = last_pack + 8'd1;
        sp.total = FRAME_LIMIT;
        send_frame(sp);
        sp.total = FRAME_LIMIT + 1;
        send_frame(sp);
        // ack table lies past the frame end
        sp = good_spec(data_t);
        sp.pack = last_pack + 8'd1;
        sp.len_field = 8'hFF;
        send_frame(sp);
    endtask

    task automatic test_code_priority();
        frame_spec_t sp;
        pick_settings();
        type_map = 24'hFFFFFF;
        load_settings();
        sp = good_spec(8'hFF);
        sp.pack = last_pack + 8'd1;
        send_frame(sp);
        send_frame(good_spec(8'hFF));
        type_map = {8'h5A, 8'h5A, 8'hA5};
        load_settings();
        send_frame(good_spec(8'h5A));
        sp = good_spec(8'h5A);
        sp.slot = SLOT_SET;
        send_frame(sp);
    endtask

    task automatic test_extremes();
        my_uid = '1;
        pair_uid = '1;
        bcast_uid = '1;
        dev_slot = 7'd119;
        head_code = 8'hFF;
        end_code = 8'hFF;
        type_map = 24'hFDFEFF;
        extend_ticks = 8'hFF;
        load_settings();
        repeat (2) send_frame(random_spec());
        my_uid = '0;
        pair_uid = '0;
        bcast_uid = '0;
        dev_slot = '0;
        head_code = '0;
        end_code = '0;
        type_map = 24'h020100;
        extend_ticks = '0;
        load_settings();
        repeat (2) send_frame(random_spec());
    endtask

    task automatic test_backpressure();
        frame_spec_t sp;
        pick_settings();
        load_settings();
        steady = 1'b1;
        hold_req++;
        repeat (8) begin
            sp = random_spec();
            sp.total = MIN_FRAME_BYTES + int'($urandom_range(0, 6));
            send_frame(sp);
        end
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        int mark;
        for (int phase = 0; phase < 2; phase++) begin
            pick_settings();
            load_settings();
            steady = (phase == 1);
            mark = bytes_sent;
            while (bytes_sent - mark < 30) begin
                send_frame(random_spec());
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_OWN_UID;
        cfg_wr_data <= '0;
        s_valid <= 1'b0;
        s_beat <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_actions();
        test_code_priority();
        test_extremes();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("radio_frame_receive_filter_test OK");
        end else begin
            $display("radio_frame_receive_filter_test NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/rfrf_pkg.sv
sv/rfrf_frame_track.sv
sv/radio_frame_receive_filter.sv
bench/radio_frame_receive_filter_test.sv
